// ----- src/socks_request_parser_macros.svh -----
// Assertion macros for the checker file.
// Each macro expects clk and rst_n in scope.
`ifndef SOCKS_REQUEST_PARSER_MACROS_SVH
`define SOCKS_REQUEST_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SRP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srp assertion failed");

// Next-cycle implication, disabled during reset.
`define SRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srp assertion failed");

`endif

// ----- src/srp_pkg.sv -----
// ----------------------------------------------------------------------------
// srp_pkg
// Types, codes and helper functions of the SOCKS request parser.
// ----------------------------------------------------------------------------
`default_nettype none

package srp_pkg;

    // Input beat: one client byte and the restart flag.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       new_session;
    } in_beat_t;

    // Result beat: one per input beat.
    typedef struct packed {
        logic [2:0]  event_res;
        logic [2:0]  error_code;
        logic [2:0]  protocol_version;
        logic [1:0]  command;
        logic [15:0] dst_port;
        logic [31:0] dst_ipv4;
        logic [2:0]  addr_type;
        logic [7:0]  method;
        logic [7:0]  field_byte;
        logic [7:0]  field_index;
        logic [1:0]  field_kind;
    } out_beat_t;

    typedef enum logic [4:0] {
        ST_VER,
        ST4_CD,
        ST4_PORT,
        ST4_IP,
        ST4_USERID,
        ST4_DONE,
        ST5_NMETH,
        ST5_METH,
        ST5_UPVER,
        ST5_ULEN,
        ST5_UNAME,
        ST5_PLEN,
        ST5_PASSWD,
        ST5_VER2,
        ST5_CMD,
        ST5_RSV,
        ST5_ATYP,
        ST5_ALEN,
        ST5_ADDR,
        ST5_PORT,
        ST5_DONE,
        ST_FAIL
    } parse_state_t;

    // Event codes
    localparam logic [2:0] EV_CONSUMED   = 3'd0;
    localparam logic [2:0] EV_FIELD      = 3'd1;
    localparam logic [2:0] EV_SOCKS4_DONE = 3'd2;
    localparam logic [2:0] EV_METHOD     = 3'd3;
    localparam logic [2:0] EV_SOCKS5_DONE = 3'd4;
    localparam logic [2:0] EV_ERROR      = 3'd5;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_VERSION   = 3'd1;
    localparam logic [2:0] ERR_S4_CMD    = 3'd2;
    localparam logic [2:0] ERR_USERID    = 3'd3;
    localparam logic [2:0] ERR_AUTH_VER  = 3'd4;
    localparam logic [2:0] ERR_S5_VER    = 3'd5;
    localparam logic [2:0] ERR_S5_CMD    = 3'd6;
    localparam logic [2:0] ERR_ATYP      = 3'd7;

    // Field kinds
    localparam logic [1:0] FK_USERID     = 2'd0;
    localparam logic [1:0] FK_USERNAME   = 2'd1;
    localparam logic [1:0] FK_PASSWORD   = 2'd2;
    localparam logic [1:0] FK_ADDRESS    = 2'd3;

    // Protocol bytes
    localparam logic [7:0] BYTE_ZERO     = 8'd0;
    localparam logic [7:0] VER_SOCKS4    = 8'd4;
    localparam logic [7:0] VER_SOCKS5    = 8'd5;
    localparam logic [7:0] VER_USERPASS  = 8'd1;
    localparam logic [7:0] CMD_CONNECT   = 8'd1;
    localparam logic [7:0] CMD_BIND      = 8'd2;
    localparam logic [7:0] CMD_UDP       = 8'd3;
    localparam logic [2:0] ATYP_IPV4     = 3'd1;
    localparam logic [2:0] ATYP_DOMAIN   = 3'd3;
    localparam logic [2:0] ATYP_IPV6     = 3'd4;
    localparam logic [7:0] IPV4_LEN      = 8'd4;
    localparam logic [7:0] IPV6_LEN      = 8'd16;
    localparam logic [7:0] PORT_LEN      = 8'd2;

    // Reported protocol versions
    localparam logic [2:0] PROTO_NONE    = 3'd0;
    localparam logic [2:0] PROTO_V4      = 3'd4;
    localparam logic [2:0] PROTO_V5      = 3'd5;

    // Methods
    localparam logic [7:0] METHOD_NOAUTH   = 8'd0;
    localparam logic [7:0] METHOD_USERPASS = 8'd2;
    localparam logic [7:0] METHOD_NONE_OK  = 8'd255;

    localparam logic [7:0] USERID_LIMIT_RESET = 8'd255;

    // Bit 1: user/password offered, bit 0: no-auth offered.
    function automatic logic [7:0] chosen_method(input logic [1:0] seen);
        logic [7:0] m;
        if (seen[1])
            m = METHOD_USERPASS;
        else if (seen[0])
            m = METHOD_NOAUTH;
        else
            m = METHOD_NONE_OK;
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- src/srp_parse.sv -----
// ----------------------------------------------------------------------------
// srp_parse
// Session state registers and the per-byte parse step.
// ----------------------------------------------------------------------------
`default_nettype none

module srp_parse (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire srp_pkg::in_beat_t beat,
    input  wire logic [7:0]        max_userid_len,
    output srp_pkg::out_beat_t     result
);

    srp_pkg::parse_state_t state_reg, state_next;
    logic [2:0]  fail_code_reg, fail_code_next;
    logic        is_v5_reg, is_v5_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [15:0] port_reg, port_next;
    logic [31:0] ip_reg, ip_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [7:0]  field_len_reg, field_len_next;
    logic [1:0]  methods_seen_reg, methods_seen_next;
    logic [2:0]  atyp_reg, atyp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= srp_pkg::ST_VER;
            fail_code_reg    <= srp_pkg::ERR_NONE;
            is_v5_reg        <= 1'b0;
            cmd_reg          <= '0;
            port_reg         <= '0;
            ip_reg           <= '0;
            byte_count_reg   <= '0;
            field_len_reg    <= '0;
            methods_seen_reg <= '0;
            atyp_reg         <= '0;
        end
        else if (fire)
        begin
            state_reg        <= state_next;
            fail_code_reg    <= fail_code_next;
            is_v5_reg        <= is_v5_next;
            cmd_reg          <= cmd_next;
            port_reg         <= port_next;
            ip_reg           <= ip_next;
            byte_count_reg   <= byte_count_next;
            field_len_reg    <= field_len_next;
            methods_seen_reg <= methods_seen_next;
            atyp_reg         <= atyp_next;
        end
    end

    always_comb
    begin
        logic [7:0]            b;
        logic [7:0]            bc_inc;
        logic [7:0]            meth;
        logic [2:0]            ev;
        logic [7:0]            fbyte;
        logic [7:0]            findex;
        logic [1:0]            fkind;
        srp_pkg::parse_state_t cur_state;

        b = beat.rx_byte;

        // Restart clears the session before the byte is taken.
        if (beat.new_session)
        begin
            cur_state         = srp_pkg::ST_VER;
            fail_code_next    = srp_pkg::ERR_NONE;
            is_v5_next        = 1'b0;
            cmd_next          = '0;
            port_next         = '0;
            ip_next           = '0;
            byte_count_next   = '0;
            field_len_next    = '0;
            methods_seen_next = '0;
            atyp_next         = '0;
        end
        else
        begin
            cur_state         = state_reg;
            fail_code_next    = fail_code_reg;
            is_v5_next        = is_v5_reg;
            cmd_next          = cmd_reg;
            port_next         = port_reg;
            ip_next           = ip_reg;
            byte_count_next   = byte_count_reg;
            field_len_next    = field_len_reg;
            methods_seen_next = methods_seen_reg;
            atyp_next         = atyp_reg;
        end

        state_next = cur_state;
        bc_inc     = byte_count_next + 8'd1;
        ev         = srp_pkg::EV_CONSUMED;
        fbyte      = '0;
        findex     = '0;
        fkind      = '0;

        case (cur_state)
            srp_pkg::ST_VER:
            begin
                if (b == srp_pkg::VER_SOCKS5)
                begin
                    is_v5_next = 1'b1;
                    state_next = srp_pkg::ST5_NMETH;
                end
                else if (b == srp_pkg::VER_SOCKS4)
                    state_next = srp_pkg::ST4_CD;
                else
                begin
                    state_next     = srp_pkg::ST_FAIL;
                    fail_code_next = srp_pkg::ERR_VERSION;
                    ev             = srp_pkg::EV_ERROR;
                end
            end
            srp_pkg::ST4_CD:
            begin
                if (b == srp_pkg::CMD_CONNECT || b == srp_pkg::CMD_BIND)
                begin
                    cmd_next        = b[1:0];
                    state_next      = srp_pkg::ST4_PORT;
                    byte_count_next = '0;
                end
                else
                begin
                    state_next     = srp_pkg::ST_FAIL;
                    fail_code_next = srp_pkg::ERR_S4_CMD;
                    ev             = srp_pkg::EV_ERROR;
                end
            end
            srp_pkg::ST4_PORT:
            begin
                port_next       = {port_next[7:0], b};
                byte_count_next = bc_inc;
                if (bc_inc >= srp_pkg::PORT_LEN)
                begin
                    state_next      = srp_pkg::ST4_IP;
                    byte_count_next = '0;
                end
            end
            srp_pkg::ST4_IP:
            begin
                ip_next         = {ip_next[23:0], b};
                byte_count_next = bc_inc;
                if (bc_inc >= srp_pkg::IPV4_LEN)
                begin
                    state_next      = srp_pkg::ST4_USERID;
                    byte_count_next = '0;
                end
            end
            srp_pkg::ST4_USERID:
            begin
                if (byte_count_next >= max_userid_len)
                begin
                    state_next     = srp_pkg::ST_FAIL;
                    fail_code_next = srp_pkg::ERR_USERID;
                    ev             = srp_pkg::EV_ERROR;
                end
                else if (b == srp_pkg::BYTE_ZERO)
                begin
                    ev         = srp_pkg::EV_SOCKS4_DONE;
                    state_next = srp_pkg::ST4_DONE;
                end
                else
                begin
                    ev              = srp_pkg::EV_FIELD;
                    fbyte           = b;
                    findex          = byte_count_next;
                    fkind           = srp_pkg::FK_USERID;
                    byte_count_next = bc_inc;
                end
            end
            srp_pkg::ST5_NMETH:
            begin
                field_len_next    = b;
                byte_count_next   = '0;
                methods_seen_next = '0;
                if (b == srp_pkg::BYTE_ZERO)
                begin
                    // Empty method list: nothing acceptable.
                    ev             = srp_pkg::EV_METHOD;
                    state_next     = srp_pkg::ST_FAIL;
                    fail_code_next = srp_pkg::ERR_NONE;
                end
                else
                    state_next = srp_pkg::ST5_METH;
            end
            srp_pkg::ST5_METH:
            begin
                if (b == srp_pkg::METHOD_NOAUTH)
                    methods_seen_next[0] = 1'b1;
                if (b == srp_pkg::METHOD_USERPASS)
                    methods_seen_next[1] = 1'b1;
                byte_count_next = bc_inc;
                if (bc_inc >= field_len_next)
                begin
                    ev = srp_pkg::EV_METHOD;
                    if (methods_seen_next[1])
                        state_next = srp_pkg::ST5_UPVER;
                    else if (methods_seen_next[0])
                        state_next = srp_pkg::ST5_VER2;
                    else
                    begin
                        state_next     = srp_pkg::ST_FAIL;
                        fail_code_next = srp_pkg::ERR_NONE;
                    end
                end
            end
            srp_pkg::ST5_UPVER:
            begin
                if (b == srp_pkg::VER_USERPASS)
                    state_next = srp_pkg::ST5_ULEN;
                else
                begin
                    state_next     = srp_pkg::ST_FAIL;
                    fail_code_next = srp_pkg::ERR_AUTH_VER;
                    ev             = srp_pkg::EV_ERROR;
                end
            end
            srp_pkg::ST5_ULEN:
            begin
                field_len_next  = b;
                byte_count_next = '0;
                state_next      = (b == srp_pkg::BYTE_ZERO) ? srp_pkg::ST5_PLEN
                                                            : srp_pkg::ST5_UNAME;
            end
            srp_pkg::ST5_UNAME:
            begin
                ev              = srp_pkg::EV_FIELD;
                fbyte           = b;
                findex          = byte_count_next;
                fkind           = srp_pkg::FK_USERNAME;
                byte_count_next = bc_inc;
                if (bc_inc >= field_len_next)
                    state_next = srp_pkg::ST5_PLEN;
            end
            srp_pkg::ST5_PLEN:
            begin
                field_len_next  = b;
                byte_count_next = '0;
                state_next      = (b == srp_pkg::BYTE_ZERO) ? srp_pkg::ST5_VER2
                                                            : srp_pkg::ST5_PASSWD;
            end
            srp_pkg::ST5_PASSWD:
            begin
                ev              = srp_pkg::EV_FIELD;
                fbyte           = b;
                findex          = byte_count_next;
                fkind           = srp_pkg::FK_PASSWORD;
                byte_count_next = bc_inc;
                if (bc_inc >= field_len_next)
                    state_next = srp_pkg::ST5_VER2;
            end
            srp_pkg::ST5_VER2:
            begin
                if (b == srp_pkg::VER_SOCKS5)
                    state_next = srp_pkg::ST5_CMD;
                else
                begin
                    state_next     = srp_pkg::ST_FAIL;
                    fail_code_next = srp_pkg::ERR_S5_VER;
                    ev             = srp_pkg::EV_ERROR;
                end
            end
            srp_pkg::ST5_CMD:
            begin
                if (b == srp_pkg::CMD_CONNECT || b == srp_pkg::CMD_BIND
                    || b == srp_pkg::CMD_UDP)
                begin
                    cmd_next   = b[1:0];
                    state_next = srp_pkg::ST5_RSV;
                end
                else
                begin
                    state_next     = srp_pkg::ST_FAIL;
                    fail_code_next = srp_pkg::ERR_S5_CMD;
                    ev             = srp_pkg::EV_ERROR;
                end
            end
            srp_pkg::ST5_RSV:
                state_next = srp_pkg::ST5_ATYP;
            srp_pkg::ST5_ATYP:
            begin
                byte_count_next = '0;
                if (b == {5'd0, srp_pkg::ATYP_IPV4})
                begin
                    atyp_next      = srp_pkg::ATYP_IPV4;
                    field_len_next = srp_pkg::IPV4_LEN;
                    state_next     = srp_pkg::ST5_ADDR;
                end
                else if (b == {5'd0, srp_pkg::ATYP_DOMAIN})
                begin
                    atyp_next  = srp_pkg::ATYP_DOMAIN;
                    state_next = srp_pkg::ST5_ALEN;
                end
                else if (b == {5'd0, srp_pkg::ATYP_IPV6})
                begin
                    atyp_next      = srp_pkg::ATYP_IPV6;
                    field_len_next = srp_pkg::IPV6_LEN;
                    state_next     = srp_pkg::ST5_ADDR;
                end
                else
                begin
                    state_next     = srp_pkg::ST_FAIL;
                    fail_code_next = srp_pkg::ERR_ATYP;
                    ev             = srp_pkg::EV_ERROR;
                end
            end
            srp_pkg::ST5_ALEN:
            begin
                field_len_next  = b;
                byte_count_next = '0;
                state_next      = (b == srp_pkg::BYTE_ZERO) ? srp_pkg::ST5_PORT
                                                            : srp_pkg::ST5_ADDR;
            end
            srp_pkg::ST5_ADDR:
            begin
                ev              = srp_pkg::EV_FIELD;
                fbyte           = b;
                findex          = byte_count_next;
                fkind           = srp_pkg::FK_ADDRESS;
                byte_count_next = bc_inc;
                if (bc_inc >= field_len_next)
                begin
                    state_next      = srp_pkg::ST5_PORT;
                    byte_count_next = '0;
                end
            end
            srp_pkg::ST5_PORT:
            begin
                port_next       = {port_next[7:0], b};
                byte_count_next = bc_inc;
                if (bc_inc >= srp_pkg::PORT_LEN)
                begin
                    ev         = srp_pkg::EV_SOCKS5_DONE;
                    state_next = srp_pkg::ST5_DONE;
                end
            end
            srp_pkg::ST_FAIL:
                ev = srp_pkg::EV_ERROR;
            default:
                ; // request complete: consume and hold
        endcase

        if (is_v5_next && state_next != srp_pkg::ST5_NMETH
            && state_next != srp_pkg::ST5_METH)
            meth = srp_pkg::chosen_method(methods_seen_next);
        else
            meth = srp_pkg::METHOD_NOAUTH;

        result.event_res  = ev;
        result.error_code = (ev == srp_pkg::EV_ERROR) ? fail_code_next : srp_pkg::ERR_NONE;
        if (is_v5_next)
            result.protocol_version = srp_pkg::PROTO_V5;
        else if (state_next == srp_pkg::ST_VER
                 || (state_next == srp_pkg::ST_FAIL
                     && fail_code_next == srp_pkg::ERR_VERSION))
            result.protocol_version = srp_pkg::PROTO_NONE;
        else
            result.protocol_version = srp_pkg::PROTO_V4;
        result.command     = cmd_next;
        result.dst_port    = port_next;
        result.dst_ipv4    = ip_next;
        result.addr_type   = atyp_next;
        result.method      = meth;
        result.field_byte  = fbyte;
        result.field_index = findex;
        result.field_kind  = fkind;
    end

endmodule

`default_nettype wire

// ----- src/socks_request_parser.sv -----
// ----------------------------------------------------------------------------
// socks_request_parser
// Byte-serial SOCKS4/SOCKS5 client handshake parser.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the client's bytes on the in channel (in_valid/in_stall/in_data),
//   one beat per byte. Set in_data.new_session on the first byte of a new
//   connection to restart the parser at the version byte.
//   Every input beat yields exactly one result beat on the out channel:
//   an event code, the fields parsed so far, and for user id, name,
//   password and address bytes the byte with its index and field kind.
//   Path: an accepted beat waits in the input register, and its result
//   is loaded into the result register once that is free (two register stages).
//   Throughput: one byte per cycle while out_stall stays low, set by the
//   combinational parse step between the two registers.
//   Stall: while out_stall holds a result, the input register still takes
//   one more beat; in_stall rises only when both registers are full.
//   Reset: clears the session to "expect version byte", empties both
//   registers and sets the user id limit to 255.
//   cfg_we/cfg_data write the SOCKS4 user id limit (terminating zero
//   included); write it only while no beats are in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module socks_request_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire srp_pkg::in_beat_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output srp_pkg::out_beat_t      out_data,
    input  wire logic               cfg_we,
    input  wire logic [7:0]         cfg_data
);

    logic               in_valid_reg, in_valid_next;
    srp_pkg::in_beat_t  in_data_reg;
    logic               out_valid_reg, out_valid_next;
    srp_pkg::out_beat_t out_data_reg;
    logic [7:0]         max_userid_len_reg;
    srp_pkg::out_beat_t result;
    logic               fire;
    logic               in_take;

    // Advance the held byte whenever the result register is free or drains.
    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (fire)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            max_userid_len_reg <= srp_pkg::USERID_LIMIT_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                max_userid_len_reg <= cfg_data;
        end
    end

    // Payload registers: load only, no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_data_reg <= in_data;
        if (fire)
            out_data_reg <= result;
    end

    srp_parse u_parse (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .beat           (in_data_reg),
        .max_userid_len (max_userid_len_reg),
        .result         (result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- src/srp_checker.sv -----
// ----------------------------------------------------------------------------
// srp_checker
// Port-level checks of the SOCKS request parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "socks_request_parser_macros.svh"

module srp_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire srp_pkg::out_beat_t out_data
);

    logic no_field_beat;
    logic field_clear;
    logic no_error_beat;

    assign no_field_beat = out_valid && (out_data.event_res != srp_pkg::EV_FIELD);
    assign field_clear   = (out_data.field_byte == 8'd0) && (out_data.field_index == 8'd0)
                           && (out_data.field_kind == 2'd0);
    assign no_error_beat = out_valid && (out_data.event_res != srp_pkg::EV_ERROR);

    // A stalled result beat holds.
    `SRP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // Input backpressure only comes from a full, stalled result stage.
    `SRP_ASSERT_IMPLY(a_stall_cause, in_stall, out_valid && out_stall)

    // Field bytes are zero unless the beat carries one.
    `SRP_ASSERT_IMPLY(a_field_zero, no_field_beat, field_clear)

    // Error code is reported only with the error event.
    `SRP_ASSERT_IMPLY(a_err_only, no_error_beat, out_data.error_code == srp_pkg::ERR_NONE)

endmodule

bind socks_request_parser srp_checker u_srp_checker (.*);

`default_nettype wire

// ----- dv/socks_request_parser_sb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Handshake scoreboard for the SOCKS request parser
// Tracks the client handshake byte by byte and checks each result beat in
// order against the result that the parse should give.
// ----------------------------------------------------------------------------

package srp_tb_pkg;

    import srp_pkg::*;

    class handshake_scoreboard;

        out_beat_t    pending_results[$];
        int           mismatches;
        logic [7:0]   userid_limit;

        // Shadow of the parse session
        parse_state_t state;
        logic [2:0]   fail_code;
        logic         v5;
        logic [1:0]   cmd;
        logic [15:0]  port;
        logic [31:0]  ipv4;
        logic [7:0]   count;
        logic [7:0]   flen;
        logic [1:0]   offered;
        logic [2:0]   atyp;

        function new();
            userid_limit = USERID_LIMIT_RESET;
            mismatches   = 0;
            restart();
        endfunction

        function void restart();
            state     = ST_VER;
            fail_code = ERR_NONE;
            v5        = 1'b0;
            cmd       = '0;
            port      = '0;
            ipv4      = '0;
            count     = '0;
            flen      = '0;
            offered   = '0;
            atyp      = '0;
        endfunction

        // User/password wins over no-auth.
        function logic [7:0] pick_method();
            if (offered[1])
                return METHOD_USERPASS;
            if (offered[0])
                return METHOD_NOAUTH;
            return METHOD_NONE_OK;
        endfunction

        function void go_failed(input logic [2:0] code, inout out_beat_t r);
            state        = ST_FAIL;
            fail_code    = code;
            r.event_res  = EV_ERROR;
            r.error_code = code;
        endfunction

        function void stream_field(input logic [7:0] b, input logic [1:0] kind,
                                   inout out_beat_t r);
            r.event_res   = EV_FIELD;
            r.field_byte  = b;
            r.field_index = count;
            r.field_kind  = kind;
            count         = count + 8'd1;
        endfunction

        function void select_method(inout out_beat_t r);
            logic [7:0] m;
            m           = pick_method();
            r.event_res = EV_METHOD;
            if (m == METHOD_USERPASS)
                state = ST5_UPVER;
            else if (m == METHOD_NOAUTH)
                state = ST5_VER2;
            else
            begin
                // nothing acceptable: latch failure with no error code
                state     = ST_FAIL;
                fail_code = ERR_NONE;
            end
        endfunction

        // Advance the session by one client byte; return its result beat.
        function out_beat_t parse_byte(input in_beat_t beat);
            out_beat_t  r;
            logic [7:0] b;
            r = '0;
            b = beat.rx_byte;
            if (beat.new_session)
                restart();

            case (state)
                ST_VER:
                begin
                    if (b == VER_SOCKS5)
                    begin
                        v5    = 1'b1;
                        state = ST5_NMETH;
                    end
                    else if (b == VER_SOCKS4)
                        state = ST4_CD;
                    else
                        go_failed(ERR_VERSION, r);
                end
                ST4_CD:
                begin
                    if (b == CMD_CONNECT || b == CMD_BIND)
                    begin
                        cmd   = b[1:0];
                        state = ST4_PORT;
                        count = '0;
                    end
                    else
                        go_failed(ERR_S4_CMD, r);
                end
                ST4_PORT:
                begin
                    port  = {port[7:0], b};
                    count = count + 8'd1;
                    if (count >= PORT_LEN)
                    begin
                        state = ST4_IP;
                        count = '0;
                    end
                end
                ST4_IP:
                begin
                    ipv4  = {ipv4[23:0], b};
                    count = count + 8'd1;
                    if (count >= IPV4_LEN)
                    begin
                        state = ST4_USERID;
                        count = '0;
                    end
                end
                ST4_USERID:
                begin
                    if (count >= userid_limit)
                        go_failed(ERR_USERID, r);
                    else if (b == BYTE_ZERO)
                    begin
                        r.event_res = EV_SOCKS4_DONE;
                        state       = ST4_DONE;
                    end
                    else
                        stream_field(b, FK_USERID, r);
                end
                ST5_NMETH:
                begin
                    flen    = b;
                    count   = '0;
                    offered = '0;
                    if (b == BYTE_ZERO)
                        select_method(r);
                    else
                        state = ST5_METH;
                end
                ST5_METH:
                begin
                    if (b == METHOD_NOAUTH)
                        offered[0] = 1'b1;
                    if (b == METHOD_USERPASS)
                        offered[1] = 1'b1;
                    count = count + 8'd1;
                    if (count >= flen)
                        select_method(r);
                end
                ST5_UPVER:
                begin
                    if (b == VER_USERPASS)
                        state = ST5_ULEN;
                    else
                        go_failed(ERR_AUTH_VER, r);
                end
                ST5_ULEN:
                begin
                    flen  = b;
                    count = '0;
                    state = (b == BYTE_ZERO) ? ST5_PLEN : ST5_UNAME;
                end
                ST5_UNAME:
                begin
                    stream_field(b, FK_USERNAME, r);
                    if (count >= flen)
                        state = ST5_PLEN;
                end
                ST5_PLEN:
                begin
                    flen  = b;
                    count = '0;
                    state = (b == BYTE_ZERO) ? ST5_VER2 : ST5_PASSWD;
                end
                ST5_PASSWD:
                begin
                    stream_field(b, FK_PASSWORD, r);
                    if (count >= flen)
                        state = ST5_VER2;
                end
                ST5_VER2:
                begin
                    if (b == VER_SOCKS5)
                        state = ST5_CMD;
                    else
                        go_failed(ERR_S5_VER, r);
                end
                ST5_CMD:
                begin
                    if (b >= CMD_CONNECT && b <= CMD_UDP)
                    begin
                        cmd   = b[1:0];
                        state = ST5_RSV;
                    end
                    else
                        go_failed(ERR_S5_CMD, r);
                end
                ST5_RSV:
                    state = ST5_ATYP;
                ST5_ATYP:
                begin
                    count = '0;
                    if (b == 8'(ATYP_IPV4))
                    begin
                        atyp  = ATYP_IPV4;
                        flen  = IPV4_LEN;
                        state = ST5_ADDR;
                    end
                    else if (b == 8'(ATYP_DOMAIN))
                    begin
                        atyp  = ATYP_DOMAIN;
                        state = ST5_ALEN;
                    end
                    else if (b == 8'(ATYP_IPV6))
                    begin
                        atyp  = ATYP_IPV6;
                        flen  = IPV6_LEN;
                        state = ST5_ADDR;
                    end
                    else
                        go_failed(ERR_ATYP, r);
                end
                ST5_ALEN:
                begin
                    flen  = b;
                    count = '0;
                    state = (b == BYTE_ZERO) ? ST5_PORT : ST5_ADDR;
                end
                ST5_ADDR:
                begin
                    stream_field(b, FK_ADDRESS, r);
                    if (count >= flen)
                    begin
                        state = ST5_PORT;
                        count = '0;
                    end
                end
                ST5_PORT:
                begin
                    port  = {port[7:0], b};
                    count = count + 8'd1;
                    if (count >= PORT_LEN)
                    begin
                        r.event_res = EV_SOCKS5_DONE;
                        state       = ST5_DONE;
                    end
                end
                ST_FAIL:
                begin
                    r.event_res  = EV_ERROR;
                    r.error_code = fail_code;
                end
                default:
                    ;   // request complete: consume and hold
            endcase

            if (v5)
                r.protocol_version = PROTO_V5;
            else if (state == ST_VER || (state == ST_FAIL && fail_code == ERR_VERSION))
                r.protocol_version = PROTO_NONE;
            else
                r.protocol_version = PROTO_V4;

            if (v5 && state != ST5_NMETH && state != ST5_METH)
                r.method = pick_method();

            r.command   = cmd;
            r.dst_port  = port;
            r.dst_ipv4  = ipv4;
            r.addr_type = atyp;
            return r;
        endfunction

        function void note_byte(input in_beat_t beat);
            pending_results.push_back(parse_byte(beat));
        endfunction

        function void flag(input string what, input logic [31:0] want,
                           input logic [31:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] MISMATCH %s: expected 0x%0h, got 0x%0h",
                         $time, what, want, got);
        endfunction

        function void check_result(input out_beat_t got);
            out_beat_t want;
            if (pending_results.size() == 0)
            begin
                flag("unexpected result beat", '0, 32'(got.event_res));
                return;
            end
            want = pending_results.pop_front();
            if (got.event_res != want.event_res)
                flag("event_res", 32'(want.event_res), 32'(got.event_res));
            if (got.error_code != want.error_code)
                flag("error_code", 32'(want.error_code), 32'(got.error_code));
            if (got.protocol_version != want.protocol_version)
                flag("protocol_version", 32'(want.protocol_version),
                     32'(got.protocol_version));
            if (got.command != want.command)
                flag("command", 32'(want.command), 32'(got.command));
            if (got.dst_port != want.dst_port)
                flag("dst_port", 32'(want.dst_port), 32'(got.dst_port));
            if (got.dst_ipv4 != want.dst_ipv4)
                flag("dst_ipv4", want.dst_ipv4, got.dst_ipv4);
            if (got.addr_type != want.addr_type)
                flag("addr_type", 32'(want.addr_type), 32'(got.addr_type));
            if (got.method != want.method)
                flag("method", 32'(want.method), 32'(got.method));
            if (got.field_byte != want.field_byte)
                flag("field_byte", 32'(want.field_byte), 32'(got.field_byte));
            if (got.field_index != want.field_index)
                flag("field_index", 32'(want.field_index), 32'(got.field_index));
            if (got.field_kind != want.field_kind)
                flag("field_kind", 32'(want.field_kind), 32'(got.field_kind));
        endfunction

        function void flag_leftovers();
            while (pending_results.size() != 0)
            begin
                flag("missing result beat", 32'(pending_results[0].event_res), '0);
                void'(pending_results.pop_front());
            end
        endfunction

    endclass

endpackage

// ----- dv/socks_request_parser_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for socks_request_parser
// Feeds SOCKS4 and SOCKS5 client handshakes, broken handshakes and noise one
// byte per beat, under several idle and stall patterns and user id limits,
// and checks every result beat against the scoreboard's own parse.
// ----------------------------------------------------------------------------

module socks_request_parser_tb;

    import srp_pkg::*;
    import srp_tb_pkg::*;

    // Cycles with no beat accepted on either side before giving up
    localparam int QUIET_LIMIT  = 5000;
    // Random beats per phase
    localparam int PHASE_BEATS  = 388;
    // Settle time after the last result; the block holds two register stages
    localparam int SETTLE_TICKS = 8;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    in_beat_t   in_data    = '0;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    out_beat_t  out_data;
    logic       cfg_we     = 1'b0;
    logic [7:0] cfg_data   = '0;

    handshake_scoreboard hs_model = new();

    in_beat_t   byte_plan[$];
    int         beats_sent     = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         quiet_cycles   = 0;

    socks_request_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: stall at random at the rate of the current phase.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Monitor: sample both channels with the values that stood before the edge,
    // check the result beat first, then log the input beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                hs_model.check_result(out_data);
            if (in_valid && !in_stall)
                hs_model.note_byte(in_data);
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Planning of byte sequences
    // ------------------------------------------------------------------

    function automatic void add_byte(input logic [7:0] b, input logic restart);
        in_beat_t beat;
        beat.rx_byte     = b;
        beat.new_session = restart;
        byte_plan.push_back(beat);
    endfunction

    function automatic void add_random_bytes(input int n);
        for (int i = 0; i < n; i++)
            add_byte(8'($urandom_range(255)), 1'b0);
    endfunction

    // Mostly short lengths, now and then near the 8-bit maximum.
    function automatic int pick_len(input int typical_max);
        if ($urandom_range(99) < 3)
            return $urandom_range(200, 255);
        return $urandom_range(0, typical_max);
    endfunction

    // Length byte followed by that many bytes of content.
    function automatic void add_counted_field(input int len);
        add_byte(8'(len), 1'b0);
        add_random_bytes(len);
    endfunction

    function automatic void plan_socks4();
        int len;
        add_byte(VER_SOCKS4, 1'b1);
        add_byte($urandom_range(1) ? CMD_BIND : CMD_CONNECT, 1'b0);
        add_random_bytes(6);    // port, then IPv4 address
        // now and then run past the largest user id limit
        len = ($urandom_range(99) < 4) ? $urandom_range(250, 260) : $urandom_range(0, 8);
        for (int i = 0; i < len; i++)
            add_byte(8'($urandom_range(1, 255)), 1'b0);
        add_byte(BYTE_ZERO, 1'b0);
        add_random_bytes($urandom_range(0, 2));
    endfunction

    function automatic void plan_socks5();
        int         n_meth;
        int         pick;
        logic [7:0] m;
        logic [1:0] offered;
        offered = 2'b00;
        add_byte(VER_SOCKS5, 1'b1);
        pick = $urandom_range(99);
        if (pick < 6)
            n_meth = 0;
        else if (pick < 9)
            n_meth = $urandom_range(200, 255);
        else
            n_meth = $urandom_range(1, 4);
        add_byte(8'(n_meth), 1'b0);
        for (int i = 0; i < n_meth; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                m = METHOD_USERPASS;
            else if (pick < 60)
                m = METHOD_NOAUTH;
            else
                m = 8'($urandom_range(255));
            if (m == METHOD_USERPASS)
                offered[1] = 1'b1;
            if (m == METHOD_NOAUTH)
                offered[0] = 1'b1;
            add_byte(m, 1'b0);
        end
        // no acceptable method: follow with a few bytes into the failed state
        if (offered == 2'b00)
        begin
            add_random_bytes($urandom_range(1, 3));
            return;
        end
        if (offered[1])
        begin
            add_byte(VER_USERPASS, 1'b0);
            add_counted_field(pick_len(6));
            add_counted_field(pick_len(6));
        end
        add_byte(VER_SOCKS5, 1'b0);
        add_byte(8'($urandom_range(CMD_CONNECT, CMD_UDP)), 1'b0);
        add_random_bytes(1);    // reserved byte
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            add_byte(8'(ATYP_IPV4), 1'b0);
            add_random_bytes(int'(IPV4_LEN));
        end
        else if (pick < 70)
        begin
            add_byte(8'(ATYP_DOMAIN), 1'b0);
            add_counted_field(pick_len(8));
        end
        else
        begin
            add_byte(8'(ATYP_IPV6), 1'b0);
            add_random_bytes(int'(IPV6_LEN));
        end
        add_random_bytes(int'(PORT_LEN));
        add_random_bytes($urandom_range(0, 2));
    endfunction

    // Raw bytes with the restart flag set at random.
    function automatic void plan_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            add_byte(8'($urandom_range(255)), ($urandom_range(99) < 25));
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Send one beat: idle at random first, then hold valid and payload
    // until the block takes the beat.
    task automatic push_beat(input in_beat_t beat);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
    endtask

    task automatic send_plan();
        foreach (byte_plan[k])
            push_beat(byte_plan[k]);
        byte_plan.delete();
    endtask

    // Drop valid and wait until every pending result has come back.
    // The loop steps the clock before each check, so the monitor has logged the last input beat.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (hs_model.pending_results.size() != 0);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Write the user id limit while the block is idle.
    task automatic write_userid_limit(input logic [7:0] limit);
        cfg_we   <= 1'b1;
        cfg_data <= limit;
        @(posedge clk);
        cfg_we   <= 1'b0;
        hs_model.userid_limit = limit;
    endtask

    // One session: a SOCKS4 or SOCKS5 handshake or noise, then maybe corrupt one byte or cut it short.
    task automatic run_session();
        int pick;
        int cut;
        pick = $urandom_range(99);
        if (pick < 40)
            plan_socks4();
        else if (pick < 85)
            plan_socks5();
        else
            plan_noise();
        if ($urandom_range(99) < 15)
            byte_plan[$urandom_range(byte_plan.size() - 1)].rx_byte = 8'($urandom_range(255));
        if ($urandom_range(99) < 10)
        begin
            cut = $urandom_range(1, byte_plan.size());
            while (byte_plan.size() > cut)
                void'(byte_plan.pop_back());
        end
        // now and then hold off the sender until the block has emptied
        if ($urandom_range(99) < 3)
            drain();
        send_plan();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        logic [7:0] limits[4];
        int         send_pct[4];
        int         stall_pct[4];

        // user id limits per phase: reset value, lower extreme, two in between
        limits[0]    = USERID_LIMIT_RESET;
        limits[1]    = 8'd1;
        limits[2]    = 8'($urandom_range(2, 16));
        limits[3]    = 8'($urandom_range(17, 254));
        send_pct[0]  = 0;
        stall_pct[0] = 0;
        send_pct[1]  = 83;
        stall_pct[1] = 0;
        send_pct[2]  = 0;
        stall_pct[2] = 83;
        send_pct[3]  = 38;
        stall_pct[3] = 38;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bad version then latched failure
        add_byte(8'hFF, 1'b1);
        add_byte(BYTE_ZERO, 1'b0);
        // bad SOCKS4 command
        add_byte(VER_SOCKS4, 1'b1);
        add_byte(CMD_UDP, 1'b0);
        // zero method count: nothing acceptable, later bytes error with code none
        add_byte(VER_SOCKS5, 1'b1);
        add_byte(BYTE_ZERO, 1'b0);
        add_byte(8'h07, 1'b0);
        // user/password chosen, bad sub-request version
        add_byte(VER_SOCKS5, 1'b1);
        add_byte(8'd1, 1'b0);
        add_byte(METHOD_USERPASS, 1'b0);
        add_byte(METHOD_USERPASS, 1'b0);
        // no-auth chosen, bad SOCKS5 command
        add_byte(VER_SOCKS5, 1'b1);
        add_byte(8'd1, 1'b0);
        add_byte(METHOD_NOAUTH, 1'b0);
        add_byte(VER_SOCKS5, 1'b0);
        add_byte(8'hFF, 1'b0);
        // SOCKS4 bind to all-ones port and address, empty user id, then a stray byte
        add_byte(VER_SOCKS4, 1'b1);
        add_byte(CMD_BIND, 1'b0);
        for (int i = 0; i < 6; i++)
            add_byte(8'hFF, 1'b0);
        add_byte(BYTE_ZERO, 1'b0);
        add_byte(8'h55, 1'b0);
        send_plan();

        // Random phases, each starting from an idle block with a new limit
        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            write_userid_limit(limits[ph]);
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = stall_pct[ph];
            while (beats_sent < 25 + (ph + 1) * PHASE_BEATS)
                run_session();
        end

        drain();
        hs_model.flag_leftovers();
        if (hs_model.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- socks_request_parser.f -----
+incdir+src
src/srp_pkg.sv
src/srp_parse.sv
src/socks_request_parser.sv
src/srp_checker.sv
dv/socks_request_parser_sb.sv
dv/socks_request_parser_tb.sv
